### src/hky_pkg.sv
`default_nettype none

package hky_pkg;

  // Model parameters held in the configuration registers.
  typedef struct packed {
    logic [15:0] freq_a;
    logic [15:0] freq_c;
    logic [15:0] freq_g;
    logic [15:0] freq_t;
    logic [15:0] trans_ratio;
  } hky_cfg_t;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_FREQ_A      = 3'd0,
    REG_FREQ_C      = 3'd1,
    REG_FREQ_G      = 3'd2,
    REG_FREQ_T      = 3'd3,
    REG_TRANS_RATIO = 3'd4
  } hky_reg_t;

  // Divider widths: dividend, divisor and quotient.
  localparam int DIV_V_W = 80;
  localparam int DIV_D_W = 52;
  localparam int DIV_Q_W = 34;

  // Exponential constants.
  localparam logic [31:0] EXP_ONE       = 32'h8000_0000;
  localparam logic [26:0] EXP_ARG_MAX   = 27'h400_0000;
  localparam logic [5:0]  EXP_QBITS     = 6'd28;
  localparam logic [31:0] DIV3_RECIP    = 32'hAAAA_AAAB;
  localparam logic [3:0]  EXP_SQUARINGS = 4'd10;
  localparam logic [34:0] F_ONE         = 35'h100_0000;
  localparam logic [20:0] X_ONE         = 21'h10_0000;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHECK,
    DV_RUN
  } hky_div_state_t;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_MUL_A,
    EX_MUL_B,
    EX_DIV3,
    EX_SQ_A,
    EX_SQ_B,
    EX_ROUND
  } hky_exp_state_t;

  typedef enum logic [4:0] {
    CS_IDLE,
    CS_D_SRSY,
    CS_D_AG,
    CS_D_CT,
    CS_D_SUM,
    CS_D_K,
    CS_F_R,
    CS_F_Y,
    CS_F_DONE,
    CS_TF_MUL,
    CS_TF_SUM,
    CS_TF_DIV,
    CS_TF_WAIT,
    CS_TF_EXP,
    CS_TF_EWAIT,
    CS_C_PS,
    CS_C_PM,
    CS_C_XB,
    CS_C_YD,
    CS_C_YT,
    CS_C_OTH,
    CS_C_LAST,
    CS_R_NUM,
    CS_R_DIV,
    CS_R_WAIT,
    CS_PUSH
  } hky_core_state_t;

endpackage

`default_nettype wire

### src/hky_fifo.sv
`default_nettype none

module hky_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // Storage for the waiting beats.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/hky_div.sv
`default_nettype none

module hky_div import hky_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [DIV_V_W-1:0] v,
  input  wire logic [DIV_D_W-1:0] dv,
  input  wire logic [5:0]         qbits,
  output logic                    done,
  output logic                    sat,
  output logic      [DIV_Q_W-1:0] q
);

  hky_div_state_t state_r, state_nxt;

  logic [DIV_V_W-1:0] v_r;
  logic [DIV_D_W-1:0] dv_r;
  logic [5:0]         qb_r;
  logic [5:0]         cnt_r;
  logic [DIV_D_W-1:0] rem_r;
  logic [DIV_Q_W-1:0] lo_r;
  logic [DIV_Q_W-1:0] q_r;
  logic               sat_r;
  logic               done_r;
  logic               over;
  logic [DIV_D_W:0]   rem2;
  logic               fits;

  // Quotient would not fit in qbits bits (also catches a zero divisor).
  assign over = ({33'b0, v_r} >= ({dv_r, 33'b0} >> (6'd33 - qb_r)));
  assign rem2 = {rem_r, lo_r[DIV_Q_W-1]};
  assign fits = (rem2 >= {1'b0, dv_r});

  assign done = done_r;
  assign sat  = sat_r;
  assign q    = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= ((state_r == DV_CHECK) && over) ||
                 ((state_r == DV_RUN) && (cnt_r == 6'd1));
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DV_IDLE:  if (start) state_nxt = DV_CHECK;
      DV_CHECK: state_nxt = over ? DV_IDLE : DV_RUN;
      DV_RUN:   if (cnt_r == 6'd1) state_nxt = DV_IDLE;
      default:  state_nxt = DV_IDLE;
    endcase
  end

  // Restoring division, one quotient bit a cycle.
  always_ff @(posedge clk) begin
    unique case (state_r)
      DV_IDLE: begin
        if (start) begin
          v_r  <= v;
          dv_r <= dv;
          qb_r <= qbits;
        end
      end
      DV_CHECK: begin
        sat_r <= over;
        q_r   <= '0;
        rem_r <= DIV_D_W'(v_r >> qb_r);
        lo_r  <= v_r[DIV_Q_W-1:0] << (6'(DIV_Q_W) - qb_r);
        cnt_r <= qb_r;
      end
      DV_RUN: begin
        rem_r <= fits ? DIV_D_W'(rem2 - {1'b0, dv_r}) : rem2[DIV_D_W-1:0];
        q_r   <= {q_r[DIV_Q_W-2:0], fits};
        lo_r  <= {lo_r[DIV_Q_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### src/hky_exp.sv
`default_nettype none

module hky_exp import hky_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [26:0] r,
  output logic             done,
  output logic      [20:0] res
);

  hky_exp_state_t state_r, state_nxt;

  logic [26:0] r_r;
  logic [31:0] h_r;
  logic [63:0] prod_r;
  logic [1:0]  step_r;
  logic [3:0]  cnt_r;
  logic [20:0] res_r;
  logic        done_r;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [26:0] v;
  logic [32:0] sq_rnd;
  logic [31:0] h_rnd;

  assign v      = prod_r[57:31];
  assign sq_rnd = prod_r[63:31] + 33'(prod_r[30]);
  assign h_rnd  = h_r + 32'd1024;
  assign done   = done_r;
  assign res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EX_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == EX_ROUND);
    end
  end

  // Sequencer and multiplier operand selection.
  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      EX_IDLE: if (start) state_nxt = EX_MUL_A;
      EX_MUL_A: begin
        mul_a     = {5'b0, r_r};
        mul_b     = h_r;
        state_nxt = EX_MUL_B;
      end
      EX_MUL_B: begin
        if (step_r == 2'd0) begin
          mul_a     = {5'b0, v};
          mul_b     = DIV3_RECIP;
          state_nxt = EX_DIV3;
        end else if (step_r == 2'd1) begin
          state_nxt = EX_MUL_A;
        end else begin
          state_nxt = EX_SQ_A;
        end
      end
      EX_DIV3: state_nxt = EX_MUL_A;
      EX_SQ_A: begin
        mul_a     = h_r;
        mul_b     = h_r;
        state_nxt = EX_SQ_B;
      end
      EX_SQ_B: state_nxt = (cnt_r == EXP_SQUARINGS - 4'd1) ? EX_ROUND : EX_SQ_A;
      EX_ROUND: state_nxt = EX_IDLE;
      default: state_nxt = EX_IDLE;
    endcase
  end

  // Horner steps of the series, then repeated squaring.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      EX_IDLE: begin
        if (start) begin
          r_r    <= r;
          h_r    <= EXP_ONE - {7'b0, r[26:2]};
          step_r <= 2'd0;
        end
      end
      EX_MUL_B: begin
        if (step_r == 2'd1) begin
          h_r    <= EXP_ONE - {6'b0, v[26:1]};
          step_r <= 2'd2;
        end else if (step_r == 2'd2) begin
          h_r   <= EXP_ONE - {5'b0, v};
          cnt_r <= '0;
        end
      end
      EX_DIV3: begin
        h_r    <= EXP_ONE - {1'b0, prod_r[63:33]};
        step_r <= 2'd1;
      end
      EX_SQ_B: begin
        h_r   <= sq_rnd[31:0];
        cnt_r <= cnt_r + 1'b1;
      end
      EX_ROUND: res_r <= h_rnd[31:11];
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### src/hky_core.sv
`default_nettype none

module hky_core import hky_pkg::*; #(
  parameter int PROB_FRAC_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire hky_cfg_t                        cfg,
  input  wire logic                            in_avail,
  input  wire logic [31:0]                     in_t,
  output logic                                 in_take,
  input  wire logic                            out_full,
  output logic                                 out_push,
  output logic [3+4*(PROB_FRAC_BITS+1)-1:0]    out_data
);

  localparam int PW = PROB_FRAC_BITS + 1;
  localparam int DEN_SH = 36 - PROB_FRAC_BITS;
  localparam logic [5:0] ROW_QBITS = 6'(PW);
  localparam logic [DIV_Q_W-1:0] ONE_Q = DIV_Q_W'(1) << PROB_FRAC_BITS;

  hky_core_state_t state_r, state_nxt;

  logic [1:0]  sel_r, col_r, row_r;
  logic [31:0] t_r;
  logic [33:0] tmp_a_r;
  logic [32:0] tmp_b_r;
  logic [DIV_D_W-1:0] d_r;
  logic [34:0] fr_r, fy_r;
  logic [DIV_V_W-1:0] tfv_r;
  logic [26:0] e_r;
  logic [20:0] x_r, yr_r, yy_r;
  logic [32:0] ps_r;
  logic signed [55:0] xb_r;
  logic [37:0] yd_r;
  logic [36:0] yt_r;
  logic [53:0] oth_r;
  logic signed [57:0] base_r, num_r;
  logic [PW-1:0] prob_r [4];
  logic signed [66:0] prod_r;

  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic [16:0] sr, sy, s;
  logic [15:0] p;
  logic [20:0] y;
  logic [34:0] f_sel;
  logic signed [33:0] pm_a;
  logic [DIV_D_W-1:0] den;
  logic zero_entry;

  logic               div_start, div_done, div_sat;
  logic [DIV_V_W-1:0] div_v;
  logic [DIV_D_W-1:0] div_d;
  logic [5:0]         div_q;
  logic [DIV_Q_W-1:0] div_res;
  logic               exp_start, exp_done;
  logic [20:0]        exp_res;

  function automatic logic [34:0] grp_factor(input logic [16:0] gs, input logic [33:0] sk);
    logic signed [36:0] fv;
    fv = $signed({3'b0, sk}) + 37'sd16777216 - $signed({12'b0, gs, 8'b0});
    return (fv < 0) ? '0 : fv[34:0];
  endfunction

  // Group sums and per-column selections.
  assign sr   = {1'b0, cfg.freq_a} + {1'b0, cfg.freq_g};
  assign sy   = {1'b0, cfg.freq_c} + {1'b0, cfg.freq_t};
  assign s    = col_r[0] ? sy : sr;
  assign y    = col_r[0] ? yy_r : yr_r;
  assign pm_a = 34'sd65536 - $signed({17'b0, s});
  assign den  = DIV_D_W'(s) << DEN_SH;
  assign zero_entry = (s == '0) || (num_r <= 58'sd0);

  always_comb begin
    case (col_r)
      2'd0:    p = cfg.freq_a;
      2'd1:    p = cfg.freq_c;
      2'd2:    p = cfg.freq_g;
      default: p = cfg.freq_t;
    endcase
    case (sel_r)
      2'd0:    f_sel = F_ONE;
      2'd1:    f_sel = fr_r;
      default: f_sel = fy_r;
    endcase
  end

  hky_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .v     (div_v),
    .dv    (div_d),
    .qbits (div_q),
    .done  (div_done),
    .sat   (div_sat),
    .q     (div_res)
  );

  hky_exp u_exp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (exp_start),
    .r     (e_r),
    .done  (exp_done),
    .res   (exp_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer: next state, handshakes, unit starts and multiplier operands.
  always_comb begin
    state_nxt = state_r;
    in_take   = 1'b0;
    out_push  = 1'b0;
    div_start = 1'b0;
    div_v     = '0;
    div_d     = '0;
    div_q     = '0;
    exp_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      CS_IDLE: begin
        if (in_avail) begin
          in_take   = 1'b1;
          state_nxt = CS_D_SRSY;
        end
      end
      CS_D_SRSY: begin
        mul_a = {17'b0, sr};
        mul_b = {16'b0, sy};
        state_nxt = CS_D_AG;
      end
      CS_D_AG: begin
        mul_a = {18'b0, cfg.freq_a};
        mul_b = {17'b0, cfg.freq_g};
        state_nxt = CS_D_CT;
      end
      CS_D_CT: begin
        mul_a = {18'b0, cfg.freq_c};
        mul_b = {17'b0, cfg.freq_t};
        state_nxt = CS_D_SUM;
      end
      CS_D_SUM: state_nxt = CS_D_K;
      CS_D_K: begin
        mul_a = {1'b0, tmp_b_r};
        mul_b = {17'b0, cfg.trans_ratio};
        state_nxt = CS_F_R;
      end
      CS_F_R: begin
        mul_a = {17'b0, sr};
        mul_b = {17'b0, cfg.trans_ratio};
        state_nxt = CS_F_Y;
      end
      CS_F_Y: begin
        mul_a = {17'b0, sy};
        mul_b = {17'b0, cfg.trans_ratio};
        state_nxt = CS_F_DONE;
      end
      CS_F_DONE: state_nxt = CS_TF_MUL;
      CS_TF_MUL: begin
        mul_a = {2'b0, t_r};
        mul_b = {1'b0, f_sel[31:0]};
        state_nxt = CS_TF_SUM;
      end
      CS_TF_SUM: state_nxt = CS_TF_DIV;
      CS_TF_DIV: begin
        div_start = 1'b1;
        div_v     = tfv_r;
        div_d     = d_r;
        div_q     = EXP_QBITS;
        state_nxt = CS_TF_WAIT;
      end
      CS_TF_WAIT: if (div_done) state_nxt = CS_TF_EXP;
      CS_TF_EXP: begin
        exp_start = 1'b1;
        state_nxt = CS_TF_EWAIT;
      end
      CS_TF_EWAIT: begin
        if (exp_done) begin
          state_nxt = (sel_r == 2'd2) ? CS_C_PS : CS_TF_MUL;
        end
      end
      CS_C_PS: begin
        mul_a = {18'b0, p};
        mul_b = {16'b0, s};
        state_nxt = CS_C_PM;
      end
      CS_C_PM: begin
        mul_a = pm_a;
        mul_b = {17'b0, p};
        state_nxt = CS_C_XB;
      end
      CS_C_XB: begin
        mul_a = prod_r[33:0];
        mul_b = {12'b0, x_r};
        state_nxt = CS_C_YD;
      end
      CS_C_YD: begin
        mul_a = {17'b0, s - {1'b0, p}};
        mul_b = {12'b0, y};
        state_nxt = CS_C_YT;
      end
      CS_C_YT: begin
        mul_a = {13'b0, y};
        mul_b = {17'b0, p};
        state_nxt = CS_C_OTH;
      end
      CS_C_OTH: begin
        mul_a = {1'b0, ps_r};
        mul_b = {12'b0, X_ONE - x_r};
        state_nxt = CS_C_LAST;
      end
      CS_C_LAST: state_nxt = CS_R_NUM;
      CS_R_NUM: state_nxt = CS_R_DIV;
      CS_R_DIV: begin
        if (zero_entry) begin
          state_nxt = (row_r == 2'd3) ? CS_PUSH : CS_R_NUM;
        end else begin
          div_start = 1'b1;
          div_v     = DIV_V_W'($unsigned(num_r)) + DIV_V_W'(den >> 1);
          div_d     = den;
          div_q     = ROW_QBITS;
          state_nxt = CS_R_WAIT;
        end
      end
      CS_R_WAIT: begin
        if (div_done) begin
          state_nxt = (row_r == 2'd3) ? CS_PUSH : CS_R_NUM;
        end
      end
      CS_PUSH: begin
        if (!out_full) begin
          out_push  = 1'b1;
          state_nxt = (col_r == 2'd3) ? CS_IDLE : CS_C_PS;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  // Datapath registers, updated as the sequencer steps.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      CS_IDLE:   if (in_avail) t_r <= in_t;
      CS_D_AG:   tmp_a_r <= prod_r[33:0];
      CS_D_CT:   tmp_b_r <= prod_r[32:0];
      CS_D_SUM:  tmp_b_r <= tmp_b_r + prod_r[32:0];
      CS_F_R:    d_r <= DIV_D_W'({tmp_a_r, 8'b0}) + DIV_D_W'(prod_r[48:0]);
      CS_F_Y:    fr_r <= grp_factor(sr, prod_r[33:0]);
      CS_F_DONE: begin
        fy_r  <= grp_factor(sy, prod_r[33:0]);
        sel_r <= 2'd0;
      end
      CS_TF_SUM: begin
        tfv_r <= (DIV_V_W'(prod_r[63:0]) +
                  (DIV_V_W'({3'b0, t_r} * {32'b0, f_sel[34:32]}) << 32)) << 12;
      end
      CS_TF_WAIT: begin
        if (div_done) begin
          e_r <= (div_sat || (div_res > DIV_Q_W'(EXP_ARG_MAX))) ? EXP_ARG_MAX
                                                               : div_res[26:0];
        end
      end
      CS_TF_EWAIT: begin
        if (exp_done) begin
          case (sel_r)
            2'd0:    x_r  <= exp_res;
            2'd1:    yr_r <= exp_res;
            default: yy_r <= exp_res;
          endcase
          sel_r <= sel_r + 1'b1;
          col_r <= 2'd0;
        end
      end
      CS_C_PM:   ps_r <= prod_r[32:0];
      CS_C_YD:   xb_r <= prod_r[55:0];
      CS_C_YT: begin
        yd_r   <= prod_r[37:0];
        base_r <= $signed({5'b0, ps_r, 20'b0}) + 58'(xb_r);
      end
      CS_C_OTH:  yt_r <= prod_r[36:0];
      CS_C_LAST: begin
        oth_r <= prod_r[53:0];
        row_r <= 2'd0;
      end
      CS_R_NUM: begin
        if (row_r == col_r) begin
          num_r <= base_r + $signed({4'b0, yd_r, 16'b0});
        end else if (row_r == (col_r ^ 2'd2)) begin
          num_r <= base_r - $signed({5'b0, yt_r, 16'b0});
        end else begin
          num_r <= $signed({4'b0, oth_r});
        end
      end
      CS_R_DIV: begin
        if (zero_entry) begin
          prob_r[row_r] <= '0;
          row_r         <= row_r + 1'b1;
        end
      end
      CS_R_WAIT: begin
        if (div_done) begin
          prob_r[row_r] <= (div_sat || (div_res > ONE_Q)) ? PW'(ONE_Q)
                                                          : div_res[PW-1:0];
          row_r         <= row_r + 1'b1;
        end
      end
      CS_PUSH:   if (!out_full) col_r <= col_r + 1'b1;
      default: ;
    endcase
  end

  assign out_data = {col_r, prob_r[0], prob_r[1], prob_r[2], prob_r[3], (col_r == 2'd3)};

  // A column beat is only written into a queue with room.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full) else $error("column pushed into a full queue");

  // The divider is started once and then waited on.
  a_div_once: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> !div_start) else $error("divider restarted while busy");

  // The exponential unit is started once per decay factor.
  a_exp_once: assert property (@(posedge clk) disable iff (!rst_n)
    exp_start |=> !exp_start) else $error("exponential unit restarted");

  // A new branch length is only taken between matrices.
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == CS_D_SRSY)) else $error("item taken mid-matrix");

endmodule

`default_nettype wire

### src/hky85_transition_matrix.sv
// A branch length taken into an idle back end yields one matrix as four column beats; the
// back end takes the next branch length only after the last beat of the matrix is pushed.
// All divisions go through the shared restoring divider (one quotient bit a cycle).
// Reset (synchronous, active low) empties both queues and loads the default frequencies
// of 0.25 each and a ratio of 1.0.
`default_nettype none

module hky85_transition_matrix import hky_pkg::*; #(
  parameter int PROB_FRAC_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic [31:0]             in_branch_length,
  output logic                         empty,
  input  wire logic                    pop,
  output logic [1:0]                   out_to_base,
  output logic [PROB_FRAC_BITS:0]      out_prob_from_a,
  output logic [PROB_FRAC_BITS:0]      out_prob_from_c,
  output logic [PROB_FRAC_BITS:0]      out_prob_from_g,
  output logic [PROB_FRAC_BITS:0]      out_prob_from_t,
  output logic                         out_last_column,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [4:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int PW    = PROB_FRAC_BITS + 1;
  localparam int OUT_W = 3 + 4 * PW;

  hky_cfg_t cfg_r;

  logic              q_avail, q_empty, q_take;
  logic [31:0]       q_t;
  logic              core_push, oq_full;
  logic [OUT_W-1:0]  core_data, oq_data;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.freq_a      <= 16'd16384;
      cfg_r.freq_c      <= 16'd16384;
      cfg_r.freq_g      <= 16'd16384;
      cfg_r.freq_t      <= 16'd16384;
      cfg_r.trans_ratio <= 16'd256;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_FREQ_A:      cfg_r.freq_a      <= pwdata[15:0];
        REG_FREQ_C:      cfg_r.freq_c      <= pwdata[15:0];
        REG_FREQ_G:      cfg_r.freq_g      <= pwdata[15:0];
        REG_FREQ_T:      cfg_r.freq_t      <= pwdata[15:0];
        REG_TRANS_RATIO: cfg_r.trans_ratio <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[4:2])
      REG_FREQ_A:      prdata = {16'b0, cfg_r.freq_a};
      REG_FREQ_C:      prdata = {16'b0, cfg_r.freq_c};
      REG_FREQ_G:      prdata = {16'b0, cfg_r.freq_g};
      REG_FREQ_T:      prdata = {16'b0, cfg_r.freq_t};
      REG_TRANS_RATIO: prdata = {16'b0, cfg_r.trans_ratio};
      default:         prdata = '0;
    endcase
  end

  // Front: branch lengths wait here until the back end takes them.
  hky_fifo #(.WIDTH(32), .DEPTH(2)) u_in_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push && !full),
    .wr_data (in_branch_length),
    .full    (full),
    .rd_en   (q_take),
    .rd_data (q_t),
    .empty   (q_empty)
  );

  assign q_avail = !q_empty;

  // Back: matrix computation.
  hky_core #(.PROB_FRAC_BITS(PROB_FRAC_BITS)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_avail (q_avail),
    .in_t     (q_t),
    .in_take  (q_take),
    .out_full (oq_full),
    .out_push (core_push),
    .out_data (core_data)
  );

  // Result queue: finished column beats wait for the consumer.
  hky_fifo #(.WIDTH(OUT_W), .DEPTH(2)) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (core_push),
    .wr_data (core_data),
    .full    (oq_full),
    .rd_en   (pop && !empty),
    .rd_data (oq_data),
    .empty   (empty)
  );

  assign {out_to_base, out_prob_from_a, out_prob_from_c, out_prob_from_g,
          out_prob_from_t, out_last_column} = oq_data;

endmodule

`default_nettype wire
